>>> src/zipcd_pkg.sv
package zipcd_pkg;

  typedef enum logic [1:0] {
    OP_RESET  = 2'd0,
    OP_PASS   = 2'd1,
    OP_HEADER = 2'd2,
    OP_DATA   = 2'd3
  } zipcd_op_t;

  typedef struct packed {
    logic load_init;
    logic step_a;
    logic use_ks;
    logic load_out;
    logic step_b;
  } zipcd_cmd_t;

  localparam logic [31:0] KEY_A_INIT = 32'h12345678;
  localparam logic [31:0] KEY_B_INIT = 32'h23456789;
  localparam logic [31:0] KEY_C_INIT = 32'h34567890;
  localparam logic [31:0] LCG_MULT   = 32'd134775813;
  localparam logic [31:0] CRC_POLY   = 32'hEDB88320;

  // Reflected CRC-32 table entry for one index byte.
  function automatic logic [31:0] crc_tab(input logic [7:0] idx);
    logic [31:0] r;
    r = {24'd0, idx};
    for (int i = 0; i < 8; i++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic logic [31:0] crc_step(input logic [31:0] crc, input logic [7:0] b);
    return {8'd0, crc[31:8]} ^ crc_tab(crc[7:0] ^ b);
  endfunction

endpackage

>>> src/zipcd_ctrl.sv
module zipcd_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [1:0]          in_operation,
  output logic                out_valid,
  input  logic                out_stall,
  output zipcd_pkg::zipcd_cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_FOLD
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   accept;
  zipcd_pkg::zipcd_op_t op;

  assign op       = zipcd_pkg::zipcd_op_t'(in_operation);
  assign in_stall = (state_r != S_IDLE) | (out_valid_r & out_stall);
  assign accept   = in_valid & ~in_stall;

  always_comb begin
    cmd.load_init = accept & (op == zipcd_pkg::OP_RESET);
    cmd.step_a    = accept & (op != zipcd_pkg::OP_RESET);
    cmd.use_ks    = (op == zipcd_pkg::OP_HEADER) | (op == zipcd_pkg::OP_DATA);
    cmd.load_out  = accept & (op == zipcd_pkg::OP_DATA);
    cmd.step_b    = (state_r == S_FOLD);
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (cmd.step_a) state_nxt = S_FOLD;
      S_FOLD: state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
    // drop the word once taken, load a new one on a data item
    out_valid_nxt = out_valid_r & out_stall;
    if (cmd.load_out) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

>>> src/zipcd_dp.sv
module zipcd_dp (
  input  logic                  clk,
  input  logic                  rst_n,
  input  zipcd_pkg::zipcd_cmd_t cmd,
  input  logic [7:0]            in_data_byte,
  output logic [7:0]            out_plain_byte
);

  logic [31:0] key_a_r, key_b_r, key_c_r;
  logic [7:0]  plain_r;
  logic [15:0] ks_t;
  logic [15:0] ks_prod;
  logic [7:0]  plain;
  logic [31:0] key_a_new;
  logic [31:0] lcg;

  // First half: keystream, plaintext, CRC on key_a, low byte into key_b.
  assign ks_t      = key_c_r[15:0] | 16'h0002;
  assign ks_prod   = ks_t * (ks_t ^ 16'h0001);
  assign plain     = cmd.use_ks ? (in_data_byte ^ ks_prod[15:8]) : in_data_byte;
  assign key_a_new = zipcd_pkg::crc_step(key_a_r, plain);

  // Second half: LCG step on key_b, CRC on key_c with the top byte of the new key_b.
  assign lcg = key_b_r * zipcd_pkg::LCG_MULT + 32'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_a_r <= zipcd_pkg::KEY_A_INIT;
      key_b_r <= zipcd_pkg::KEY_B_INIT;
      key_c_r <= zipcd_pkg::KEY_C_INIT;
    end else if (cmd.load_init) begin
      key_a_r <= zipcd_pkg::KEY_A_INIT;
      key_b_r <= zipcd_pkg::KEY_B_INIT;
      key_c_r <= zipcd_pkg::KEY_C_INIT;
    end else if (cmd.step_a) begin
      key_a_r <= key_a_new;
      key_b_r <= key_b_r + {24'd0, key_a_new[7:0]};
    end else if (cmd.step_b) begin
      key_b_r <= lcg;
      key_c_r <= zipcd_pkg::crc_step(key_c_r, lcg[31:24]);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) plain_r <= plain;
  end

  assign out_plain_byte = plain_r;

endmodule

>>> src/zip_stream_cipher_decrypt_top.sv
// A data byte's plaintext is registered and appears on out_plain_byte the cycle after
// it is accepted. Password, header and data bytes update key_a in the accept cycle and
// do the key_b multiply and key_c CRC in the next, holding off input; reset items do not.
// A full output register holds off new items while out_stall is high.
// Reset: synchronous active-low rst_n loads the three keys with their init
// constants and empties the output register.
module zip_stream_cipher_decrypt_top (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [1:0] in_operation,
  input  logic [7:0] in_data_byte,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] out_plain_byte
);

  zipcd_pkg::zipcd_cmd_t cmd;

  zipcd_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_operation (in_operation),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cmd          (cmd)
  );

  zipcd_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .in_data_byte   (in_data_byte),
    .out_plain_byte (out_plain_byte)
  );

endmodule

>>> src/zipcd_chk.sv
module zipcd_chk (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_stall,
  input logic [1:0] in_operation,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_plain_byte
);

  logic in_acc;
  assign in_acc = in_valid & ~in_stall;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_plain_byte))
    else $error("stalled output word changed");

  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation != zipcd_pkg::OP_RESET) |=> in_stall)
    else $error("key update cycle did not hold off input");

  a_data_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && (in_operation == zipcd_pkg::OP_DATA) |=> out_valid)
    else $error("data byte gave no output word");

  a_no_out: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !out_valid && (in_operation != zipcd_pkg::OP_DATA) |=> !out_valid)
    else $error("output word invented");

  a_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind zip_stream_cipher_decrypt_top zipcd_chk u_zipcd_chk (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_stall       (in_stall),
  .in_operation   (in_operation),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_plain_byte (out_plain_byte)
);

>>> dv/zip_stream_cipher_decrypt_top_test.sv
module zip_stream_cipher_decrypt_top_test;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int WATCHDOG_LIMIT = 4000;
  localparam int ITEM_TARGET    = 1950;
  localparam int LONG_HOLD      = 150;

  class zip_key_scoreboard;
    localparam logic [31:0] SEED_A = 32'd305419896;
    localparam logic [31:0] SEED_B = 32'd591751049;
    localparam logic [31:0] SEED_C = 32'd878082192;
    localparam logic [31:0] MULT   = 32'd134775813;
    localparam logic [31:0] POLY   = 32'hEDB88320;

    logic [31:0] key_a;
    logic [31:0] key_b;
    logic [31:0] key_c;
    logic [7:0]  plain_q[$];
    int          errors;
    int          plain_checked;
    int          op_seen[4];

    function new();
      reload_keys();
      errors        = 0;
      plain_checked = 0;
      foreach (op_seen[i]) op_seen[i] = 0;
    endfunction

    function void reload_keys();
      key_a = SEED_A;
      key_b = SEED_B;
      key_c = SEED_C;
    endfunction

    // Reflected CRC-32 over one byte, shifted out bit by bit.
    function logic [31:0] crc_fold(logic [31:0] crc, logic [7:0] b);
      logic [31:0] r;
      r = crc ^ {24'd0, b};
      for (int i = 0; i < 8; i++) begin
        r = r[0] ? ((r >> 1) ^ POLY) : (r >> 1);
      end
      return r;
    endfunction

    function void mix_keys(logic [7:0] p);
      key_a = crc_fold(key_a, p);
      key_b = key_b + {24'd0, key_a[7:0]};
      key_b = key_b * MULT + 32'd1;
      key_c = crc_fold(key_c, key_b[31:24]);
    endfunction

    function void note_word(zipcd_pkg::zipcd_op_t op, logic [7:0] b);
      logic [15:0] t;
      logic [31:0] prod;
      logic [7:0]  p;
      op_seen[op]++;
      if (op == zipcd_pkg::OP_RESET) begin
        reload_keys();
      end else if (op == zipcd_pkg::OP_PASS) begin
        mix_keys(b);
      end else begin
        t    = key_c[15:0] | 16'h0002;
        prod = t * (t ^ 16'h0001);
        p    = b ^ prod[15:8];
        mix_keys(p);
        if (op == zipcd_pkg::OP_DATA) plain_q.push_back(p);
      end
    endfunction

    function void check_plain(logic [7:0] got);
      logic [7:0] want;
      if (plain_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected plaintext word, expected none, got %02h", $time, got);
        return;
      end
      want = plain_q.pop_front();
      plain_checked++;
      if (got !== want) begin
        errors++;
        $display("%0t: plain_byte mismatch, expected %02h, got %02h", $time, want, got);
      end
    endfunction

    function int outstanding();
      return plain_q.size();
    endfunction
  endclass

  logic       clk            = 1'b0;
  logic       rst_n          = 1'b0;
  logic       in_valid       = 1'b0;
  logic       in_stall;
  logic [1:0] in_operation   = zipcd_pkg::OP_RESET;
  logic [7:0] in_data_byte   = 8'h00;
  logic       out_valid;
  logic       out_stall      = 1'b0;
  logic [7:0] out_plain_byte;

  zip_key_scoreboard sb = new();

  int  words_sent  = 0;
  int  idle_cycles = 0;
  int  hold_req    = 0;
  int  hold_left   = 0;
  bit  quiet_in    = 1'b0;
  bit  quiet_out   = 1'b0;

  zip_stream_cipher_decrypt_top u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_operation  (in_operation),
    .in_data_byte  (in_data_byte),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_plain_byte(out_plain_byte)
  );

  always #4 clk = ~clk;

  // Receiver: check accepted words, then pick the stall for the next cycle.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check_plain(out_plain_byte);
    if (hold_req > 0) begin
      hold_left = hold_req;
      hold_req  = 0;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall <= 1'b1;
    end else if (quiet_out) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= ($urandom_range(99) < 8);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("%0t: no word moved for %0d cycles, %0d plaintext words still due",
               $time, idle_cycles, sb.outstanding());
      $display("Verification failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Offer one word, hold it until accepted, then maybe idle a little.
  task automatic send_word(zipcd_pkg::zipcd_op_t op, logic [7:0] b);
    in_operation <= op;
    in_data_byte <= b;
    in_valid     <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(op, b);
    words_sent++;
    if (!quiet_in && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
  endtask

  // One archive entry: key reload, password, twelve header bytes, data.
  task automatic send_entry(int n_data);
    int n_pass;
    n_pass = $urandom_range(1, 12);
    send_word(zipcd_pkg::OP_RESET, 8'($urandom_range(255)));
    repeat (n_pass) send_word(zipcd_pkg::OP_PASS, 8'($urandom_range(255)));
    repeat (12) send_word(zipcd_pkg::OP_HEADER, 8'($urandom_range(255)));
    repeat (n_data) send_word(zipcd_pkg::OP_DATA, 8'($urandom_range(255)));
  endtask

  initial begin
    int entry;
    int n_data;
    entry = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: field extremes, data with no password, repeated resets,
    // password after data.
    send_word(zipcd_pkg::OP_RESET,  8'hFF);
    send_word(zipcd_pkg::OP_DATA,   8'h00);
    send_word(zipcd_pkg::OP_DATA,   8'hFF);
    send_word(zipcd_pkg::OP_HEADER, 8'h00);
    send_word(zipcd_pkg::OP_HEADER, 8'hFF);
    send_word(zipcd_pkg::OP_DATA,   8'h5A);
    send_word(zipcd_pkg::OP_RESET,  8'h00);
    send_word(zipcd_pkg::OP_PASS,   8'h00);
    send_word(zipcd_pkg::OP_PASS,   8'hFF);
    send_word(zipcd_pkg::OP_PASS,   8'h80);
    send_word(zipcd_pkg::OP_PASS,   8'h01);
    send_word(zipcd_pkg::OP_DATA,   8'hAA);
    send_word(zipcd_pkg::OP_DATA,   8'h55);
    send_word(zipcd_pkg::OP_RESET,  8'hA5);
    send_word(zipcd_pkg::OP_RESET,  8'h3C);
    send_word(zipcd_pkg::OP_HEADER, 8'h7F);
    send_word(zipcd_pkg::OP_DATA,   8'h80);
    send_word(zipcd_pkg::OP_PASS,   8'h61);
    send_word(zipcd_pkg::OP_DATA,   8'hFE);
    send_word(zipcd_pkg::OP_DATA,   8'h01);

    while (words_sent < ITEM_TARGET) begin
      entry++;
      quiet_in  = (entry >= 30 && entry < 45);
      quiet_out = quiet_in;
      if (entry == 10) hold_req = LONG_HOLD;
      if (entry == 20) begin
        // let everything drain before going on
        in_valid <= 1'b0;
        while (sb.outstanding() != 0) @(posedge clk);
      end
      if ($urandom_range(9) == 0) begin
        // noise: arbitrary operations in arbitrary order
        repeat ($urandom_range(1, 4))
          send_word(zipcd_pkg::zipcd_op_t'($urandom_range(3)), 8'($urandom_range(255)));
      end else begin
        n_data = ($urandom_range(9) == 0) ? $urandom_range(17, 64) : $urandom_range(1, 16);
        send_entry(n_data);
      end
    end

    in_valid <= 1'b0;
    while (sb.outstanding() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d words in %0d entries: %0d resets, %0d password, %0d header, %0d data",
             words_sent, entry, sb.op_seen[zipcd_pkg::OP_RESET],
             sb.op_seen[zipcd_pkg::OP_PASS], sb.op_seen[zipcd_pkg::OP_HEADER],
             sb.op_seen[zipcd_pkg::OP_DATA]);
    $display("%0d plaintext words checked, %0d mismatches", sb.plain_checked, sb.errors);
    if (sb.errors == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
